[rtl/core/radix_integer_literal_parser_unit_macros.svh]
// Assertion macros for the radix integer literal parser unit checker.
`ifndef RADIX_INTEGER_LITERAL_PARSER_UNIT_MACROS_SVH
`define RADIX_INTEGER_LITERAL_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RILP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RILP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rilp_pkg.sv]
// Types and constants shared by the radix integer literal parser modules.
package rilp_pkg;

    localparam int unsigned ValueWidth  = 64;
    localparam int unsigned StatusWidth = 3;
    localparam int unsigned RadixWidth  = 7;
    localparam int unsigned DigitWidth  = 6;
    localparam int unsigned CharWidth   = 8;
    localparam int unsigned OutPad      = 72 - ValueWidth - StatusWidth;

    localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;
    localparam logic [CharWidth-1:0] CH_LC_A  = 8'h61;
    localparam logic [CharWidth-1:0] CH_LC_Z  = 8'h7a;
    localparam logic [CharWidth-1:0] CH_UC_A  = 8'h41;
    localparam logic [CharWidth-1:0] CH_UC_Z  = 8'h5a;
    localparam logic [CharWidth-1:0] CH_HASH  = 8'h23;
    localparam logic [CharWidth-1:0] CH_AT    = 8'h40;
    localparam logic [CharWidth-1:0] CH_UNDER = 8'h5f;
    localparam logic [CharWidth-1:0] CH_LC_X  = 8'h78;
    localparam logic [CharWidth-1:0] CH_UC_X  = 8'h58;

    localparam logic [DigitWidth-1:0] DIGIT_AT    = 6'd62;
    localparam logic [DigitWidth-1:0] DIGIT_UNDER = 6'd63;
    localparam logic [DigitWidth-1:0] DIGIT_LC_OFS = 6'd10;
    localparam logic [DigitWidth-1:0] DIGIT_UC_HI  = 6'd36;

    localparam logic [RadixWidth-1:0] RADIX_DEC     = 7'd10;
    localparam logic [RadixWidth-1:0] RADIX_OCT     = 7'd8;
    localparam logic [RadixWidth-1:0] RADIX_HEX     = 7'd16;
    localparam logic [RadixWidth-1:0] RADIX_FOLD_MAX = 7'd36;
    localparam logic [ValueWidth-1:0] BASE_MIN      = 64'd2;
    localparam logic [ValueWidth-1:0] BASE_MAX      = 64'd64;

    localparam logic [StatusWidth-1:0] ST_OK        = 3'd0;
    localparam logic [StatusWidth-1:0] ST_INVALID   = 3'd1;
    localparam logic [StatusWidth-1:0] ST_BAD_BASE  = 3'd2;
    localparam logic [StatusWidth-1:0] ST_NO_DIGIT  = 3'd3;
    localparam logic [StatusWidth-1:0] ST_DIGIT_BIG = 3'd4;

    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_ZERO    = 4'b0010,
        PH_COLLECT = 4'b0100,
        PH_STOP    = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                  is_num;
        logic                  is_hash;
        logic                  is_zero;
        logic                  is_x;
        logic [DigitWidth-1:0] digit;
    } char_info_t;

    typedef struct packed {
        logic [StatusWidth-1:0]       status;
        logic signed [ValueWidth-1:0] value;
    } result_t;

endpackage

[rtl/core/radix_integer_literal_parser_unit.sv]
// Top level: input register, parser update stage and result register.
// A terminator's result is registered when the terminator leaves the input register, and is held until m_tready.
// Throughput: one item per cycle unless a terminator stalls; the value's multiply-add is combinational.
// Characters keep flowing while a result waits on m_tready; a terminator waits for the result register.
// Reset: aresetn, synchronous, active low; clears all parser state and both valids.
module radix_integer_literal_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [63:0] value, [66:64] status, [71:67] zero
);
    import rilp_pkg::*;

    logic                 in_valid_reg;
    logic [CharWidth-1:0] in_ch_reg;
    logic                 in_end_reg;
    logic                 out_valid_reg;
    result_t              out_reg;
    result_t              result;
    logic                 out_free;
    logic                 consume;

    assign out_free = !out_valid_reg || m_tready;
    assign consume  = in_valid_reg && (!in_end_reg || out_free);
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg  <= s_tdata;
            in_end_reg <= s_tlast;
        end
    end

    rilp_parse_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (consume),
        .ch      (in_ch_reg),
        .is_end  (in_end_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (consume && in_end_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && in_end_reg) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OutPad{1'b0}}, out_reg.status, out_reg.value};

endmodule

[rtl/core/rilp_char_decode.sv]
// Character classification and digit value decode.
module rilp_char_decode (
    input  logic [7:0]         ch,
    input  logic [6:0]         radix,
    output rilp_pkg::char_info_t info
);
    import rilp_pkg::*;

    logic is_dec;
    logic is_lc;
    logic is_uc;
    logic is_at;
    logic [CharWidth-1:0] dec_ofs;
    logic [CharWidth-1:0] lc_ofs;
    logic [CharWidth-1:0] uc_ofs;

    assign is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_lc  = (ch >= CH_LC_A) && (ch <= CH_LC_Z);
    assign is_uc  = (ch >= CH_UC_A) && (ch <= CH_UC_Z);
    assign is_at  = (ch == CH_AT);

    assign dec_ofs = ch - CH_ZERO;
    assign lc_ofs  = ch - CH_LC_A;
    assign uc_ofs  = ch - CH_UC_A;

    always_comb begin
        info.is_num  = is_dec || is_lc || is_uc || is_at || (ch == CH_UNDER);
        info.is_hash = (ch == CH_HASH);
        info.is_zero = (ch == CH_ZERO);
        info.is_x    = (ch == CH_LC_X) || (ch == CH_UC_X);
        if (is_dec) begin
            info.digit = dec_ofs[DigitWidth-1:0];
        end else if (is_lc) begin
            info.digit = lc_ofs[DigitWidth-1:0] + DIGIT_LC_OFS;
        end else if (is_uc) begin
            // uppercase folds onto lowercase for bases up to 36
            info.digit = uc_ofs[DigitWidth-1:0] +
                         ((radix <= RADIX_FOLD_MAX) ? DIGIT_LC_OFS : DIGIT_UC_HI);
        end else if (is_at) begin
            info.digit = DIGIT_AT;
        end else begin
            info.digit = DIGIT_UNDER;
        end
    end

endmodule

[rtl/core/rilp_parse_core.sv]
// Parser state registers and the per-item update logic.
module rilp_parse_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        ch,
    input  logic              is_end,
    output rilp_pkg::result_t result
);
    import rilp_pkg::*;

    logic [ValueWidth-1:0]  accum_reg, accum_next;
    logic [RadixWidth-1:0]  radix_reg, radix_next;
    logic                   fixed_reg, fixed_next;
    phase_t                 phase_reg, phase_next;
    logic                   need_reg, need_next;
    logic [StatusWidth-1:0] err_reg, err_next;

    logic [RadixWidth-1:0]  eff_radix;
    logic                   eff_fixed;
    logic [ValueWidth-1:0]  product;
    logic [StatusWidth-1:0] end_err;
    char_info_t             info;

    assign eff_radix = (phase_reg == PH_ZERO) ? RADIX_OCT : radix_reg;
    assign eff_fixed = fixed_reg || (phase_reg == PH_ZERO);

    rilp_char_decode u_decode (
        .ch    (ch),
        .radix (eff_radix),
        .info  (info)
    );

    assign product = accum_reg * {{(ValueWidth-RadixWidth){1'b0}}, eff_radix};

    assign end_err = ((err_reg == ST_OK) && need_reg) ? ST_NO_DIGIT : err_reg;

    always_comb begin
        result.status = end_err;
        result.value  = (end_err == ST_OK) ? accum_reg : '0;
    end

    always_comb begin
        accum_next = accum_reg;
        radix_next = radix_reg;
        fixed_next = fixed_reg;
        phase_next = phase_reg;
        need_next  = need_reg;
        err_next   = err_reg;
        if (is_end) begin
            accum_next = '0;
            radix_next = RADIX_DEC;
            fixed_next = 1'b0;
            phase_next = PH_START;
            need_next  = 1'b0;
            err_next   = ST_OK;
        end else if ((err_reg == ST_OK) && (phase_reg != PH_STOP)) begin
            if ((phase_reg == PH_START) && info.is_zero) begin
                phase_next = PH_ZERO;
            end else if ((phase_reg == PH_ZERO) && info.is_x) begin
                phase_next = PH_COLLECT;
                fixed_next = 1'b1;
                radix_next = RADIX_HEX;
            end else begin
                phase_next = PH_COLLECT;
                fixed_next = eff_fixed;
                radix_next = eff_radix;
                need_next  = 1'b0;
                if (need_reg && !info.is_num) begin
                    err_next = ST_NO_DIGIT;
                end else if (info.is_hash) begin
                    if (eff_fixed) begin
                        err_next = ST_INVALID;
                    end else if ((accum_reg < BASE_MIN) || (accum_reg > BASE_MAX)) begin
                        err_next = ST_BAD_BASE;
                    end else begin
                        radix_next = accum_reg[RadixWidth-1:0];
                        accum_next = '0;
                        fixed_next = 1'b1;
                        need_next  = 1'b1;
                    end
                end else if (info.is_num) begin
                    if ({1'b0, info.digit} >= eff_radix) begin
                        err_next = ST_DIGIT_BIG;
                    end else begin
                        accum_next = product +
                                     {{(ValueWidth-DigitWidth){1'b0}}, info.digit};
                    end
                end else begin
                    phase_next = PH_STOP;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg <= '0;
            radix_reg <= RADIX_DEC;
            fixed_reg <= 1'b0;
            phase_reg <= PH_START;
            need_reg  <= 1'b0;
            err_reg   <= ST_OK;
        end else if (step_en) begin
            accum_reg <= accum_next;
            radix_reg <= radix_next;
            fixed_reg <= fixed_next;
            phase_reg <= phase_next;
            need_reg  <= need_next;
            err_reg   <= err_next;
        end
    end

endmodule

[rtl/core/rilp_checker.sv]
// Port-level checker for the radix integer literal parser unit, with its bind.
`include "radix_integer_literal_parser_unit_macros.svh"

module rilp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    `RILP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result item dropped or changed while stalled")
    `RILP_ASSERT_NOW(a_status_range, aclk, aresetn, m_tvalid,
        !(m_tdata[66] && (m_tdata[65] || m_tdata[64])) && (m_tdata[71:67] == 5'd0),
        "status code out of range or padding set")
    `RILP_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && (m_tdata[66:64] != 3'd0),
        m_tdata[63:0] == 64'd0, "nonzero value with error status")
    `RILP_ASSERT_NEXT(a_reset_idle, aclk, 1'b1, !aresetn, !m_tvalid && s_tready,
        "block not idle after reset")
    `RILP_ASSERT_NOW(a_ready_free, aclk, aresetn, !m_tvalid || m_tready, s_tready,
        "input stalled with the result register free")

endmodule

bind radix_integer_literal_parser_unit rilp_checker u_rilp_checker (.*);
